[design/rtp_pkg.sv]
// shared constants, types and the arctangent table for the run-and-tumble particle step
package rtp_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_STEP_LEN  = 2'd1;
   localparam logic [1:0] REG_BOX_SIZE  = 2'd2;

   localparam logic [15:0] THRESHOLD_RESET = 16'd26214;
   localparam logic [11:0] STEP_LEN_RESET  = 12'd82;
   localparam logic [15:0] BOX_SIZE_RESET  = 16'd40960;

   // cordic gain in q30
   localparam logic [31:0] GAIN_Q30 = 32'd652032874;

   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

   // bits of the box remainder operand and its value input
   localparam int WRAP_BITS = 17;
   localparam int WRAP_VAL_W = 18;

   typedef struct packed {
      logic        done;
      logic [15:0] value;
   } wrap_stat_type;

   // arctangent per iteration, full turn is 2^32
   function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
      logic signed [33:0] v;
      case (idx)
         5'd0:    v = 34'sh020000000;
         5'd1:    v = 34'sh012E4051D;
         5'd2:    v = 34'sh009FB385B;
         5'd3:    v = 34'sh0051111D4;
         5'd4:    v = 34'sh0028B0D43;
         5'd5:    v = 34'sh00145D7E1;
         5'd6:    v = 34'sh000A2F61E;
         5'd7:    v = 34'sh000517C55;
         5'd8:    v = 34'sh00028BE53;
         5'd9:    v = 34'sh000145F2E;
         5'd10:   v = 34'sh0000A2F98;
         5'd11:   v = 34'sh0000517CC;
         5'd12:   v = 34'sh000028BE6;
         5'd13:   v = 34'sh0000145F3;
         5'd14:   v = 34'sh00000A2F9;
         5'd15:   v = 34'sh00000517C;
         5'd16:   v = 34'sh0000028BE;
         5'd17:   v = 34'sh00000145F;
         5'd18:   v = 34'sh000000A2F;
         5'd19:   v = 34'sh000000517;
         5'd20:   v = 34'sh00000028B;
         5'd21:   v = 34'sh000000145;
         5'd22:   v = 34'sh0000000A2;
         5'd23:   v = 34'sh000000051;
         default: v = 34'sh000000000;
      endcase
      return v;
   endfunction

endpackage

[design/rtp_wrap.sv]
// serial floor modulo of a signed position by the box size, one bit per cycle
module rtp_wrap
   import rtp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [WRAP_VAL_W-1:0] value,
   input  logic [WRAP_BITS-1:0]         box,
   output wrap_stat_type                stat
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [WRAP_BITS-1:0] mag_ff, mag_in;
   logic [WRAP_BITS-1:0] rem_ff, rem_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [WRAP_BITS:0]   trial;
   logic [WRAP_VAL_W-1:0] neg_val;

   assign neg_val = WRAP_VAL_W'(-value);
   assign trial   = {rem_ff, mag_ff[WRAP_BITS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = value[WRAP_VAL_W-1];
         mag_in  = value[WRAP_VAL_W-1] ? neg_val[WRAP_BITS-1:0] : value[WRAP_BITS-1:0];
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, box}) begin
            rem_in = WRAP_BITS'(trial - {1'b0, box});
         end else begin
            rem_in = trial[WRAP_BITS-1:0];
         end
         mag_in = {mag_ff[WRAP_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(WRAP_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   // negative operands fold back from the top of the box
   assign stat = {done_ff, ((neg_ff && rem_ff != '0) ? 16'(box - rem_ff) : 16'(rem_ff))};

   a_result_in_box: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> ({1'b0, stat.value} < box))
      else $error("wrapped value not below box size");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> !busy_ff)
      else $error("remainder done while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("start did not launch the remainder");

endmodule

[design/run_and_tumble_particle_step.sv]
// run-and-tumble particle step: sequencer, shared cordic datapath and shared multiplier
// a step item runs the gain multiply, CORDIC_STEPS rotation iterations, the move, the serial
// box remainder and the squares in the shared multiplier; a start item only the box remainder.
// one item is in flight at a time, the next transfer follows the result.
// synchronous reset clears the particle state to zero and the registers to their defaults.
module run_and_tumble_particle_step
   import rtp_pkg::*;
#(
   parameter int CORDIC_STEPS       = 16,
   parameter int DISPLACEMENT_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // random_draw, random_angle, start_x, start_y
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // pos_x, pos_y, heading_out, squared_displacement
   output logic        rsp_tuser,   // tumbled
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam int DW    = DISPLACEMENT_WIDTH;
   localparam int SQW   = 2 * DW + 1;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_MULK   = 10'b0000000010,
      ST_LOADX  = 10'b0000000100,
      ST_ROTATE = 10'b0000001000,
      ST_MOVE   = 10'b0000010000,
      ST_WRAP   = 10'b0000100000,
      ST_SQX    = 10'b0001000000,
      ST_SQY    = 10'b0010000000,
      ST_SQADD  = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] thr_ff, thr_in;
   logic [11:0] step_ff, step_in;
   logic [15:0] box_ff, box_in;

   logic [15:0] pos_x_ff, pos_x_in;
   logic [15:0] pos_y_ff, pos_y_in;
   logic [15:0] heading_ff, heading_in;
   logic signed [DW-1:0] disp_x_ff, disp_x_in;
   logic signed [DW-1:0] disp_y_ff, disp_y_in;

   logic        cmd_ff, cmd_in;
   logic        tumbled_ff, tumbled_in;
   logic        flip_ff, flip_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [63:0] prod_ff;
   logic [2*DW-1:0] acc_ff, acc_in;
   logic [47:0] sq_ff, sq_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // input fields
   logic        command;
   logic [15:0] random_draw, random_angle, start_x, start_y;
   logic        req_xfer;

   assign command      = req_tuser;
   assign random_draw  = req_tdata[15:0];
   assign random_angle = req_tdata[31:16];
   assign start_x      = req_tdata[47:32];
   assign start_y      = req_tdata[63:48];
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_xfer     = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;

   // box value, zero means a full 2^16 box
   logic [WRAP_BITS-1:0] box_val;
   assign box_val = (box_ff == 16'd0) ? 17'h10000 : {1'b0, box_ff};

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [DW-1:0] abs_x, abs_y;
   assign abs_x = disp_x_ff[DW-1] ? DW'(-disp_x_ff) : DW'(disp_x_ff);
   assign abs_y = disp_y_ff[DW-1] ? DW'(-disp_y_ff) : DW'(disp_y_ff);

   always_comb begin
      unique case (state_ff)
         ST_SQX: begin
            mul_a = 32'(abs_x);
            mul_b = 32'(abs_x);
         end
         ST_SQY: begin
            mul_a = 32'(abs_y);
            mul_b = 32'(abs_y);
         end
         default: begin
            mul_a = 32'(step_ff);
            mul_b = GAIN_Q30;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // cordic micro-rotation
   logic signed [31:0] xs, ys;
   logic signed [33:0] at;
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = atan_turn(5'(cnt_ff));

   // heading into a signed angle, folded into the right half plane
   logic signed [33:0] z_head;
   assign z_head = 34'($signed({heading_ff, 16'h0000}));

   // move from the finished rotation
   logic signed [31:0] x_fin, y_fin, x_rnd, y_rnd;
   logic signed [16:0] mx, my;
   assign x_fin = flip_ff ? -x_ff : x_ff;
   assign y_fin = flip_ff ? -y_ff : y_ff;
   assign x_rnd = (x_fin + 32'sd32768) >>> 16;
   assign y_rnd = (y_fin + 32'sd32768) >>> 16;
   assign mx    = 17'(x_rnd);
   assign my    = 17'(y_rnd);

   // saturating displacement update
   logic signed [DW:0] dsum_x, dsum_y;
   logic signed [DW-1:0] dsat_x, dsat_y;
   logic signed [DW-1:0] d_hi, d_lo;
   assign d_hi   = {1'b0, {(DW-1){1'b1}}};
   assign d_lo   = {1'b1, {(DW-1){1'b0}}};
   assign dsum_x = (DW+1)'(disp_x_ff) + (DW+1)'(mx);
   assign dsum_y = (DW+1)'(disp_y_ff) + (DW+1)'(my);
   assign dsat_x = (dsum_x[DW] != dsum_x[DW-1]) ? (dsum_x[DW] ? d_lo : d_hi) : dsum_x[DW-1:0];
   assign dsat_y = (dsum_y[DW] != dsum_y[DW-1]) ? (dsum_y[DW] ? d_lo : d_hi) : dsum_y[DW-1:0];

   // squared displacement sum and clamp
   logic [SQW-1:0] sq_sum;
   logic [64:0]    sq_ext;
   assign sq_sum = SQW'(acc_ff) + SQW'(prod_ff[2*DW-1:0]);
   assign sq_ext = 65'(sq_sum);

   // box remainders for both axes
   logic                         wrap_start;
   logic signed [WRAP_VAL_W-1:0] wrap_val_x, wrap_val_y;
   wrap_stat_type                wrap_x, wrap_y;

   always_comb begin
      wrap_start = 1'b0;
      wrap_val_x = $signed({2'b00, pos_x_ff}) + WRAP_VAL_W'(mx);
      wrap_val_y = $signed({2'b00, pos_y_ff}) + WRAP_VAL_W'(my);
      if (state_ff == ST_MOVE) begin
         wrap_start = 1'b1;
      end else if (req_xfer && command) begin
         wrap_start = 1'b1;
         wrap_val_x = $signed({2'b00, start_x});
         wrap_val_y = $signed({2'b00, start_y});
      end
   end

   rtp_wrap u_wrap_x (
      .clock (clock),
      .reset (reset),
      .start (wrap_start),
      .value (wrap_val_x),
      .box   (box_val),
      .stat  (wrap_x)
   );

   rtp_wrap u_wrap_y (
      .clock (clock),
      .reset (reset),
      .start (wrap_start),
      .value (wrap_val_y),
      .box   (box_val),
      .stat  (wrap_y)
   );

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      step_in      = step_ff;
      box_in       = box_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      heading_in   = heading_ff;
      disp_x_in    = disp_x_ff;
      disp_y_in    = disp_y_ff;
      cmd_in       = cmd_ff;
      tumbled_in   = tumbled_ff;
      flip_in      = flip_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            REG_THRESHOLD: thr_in  = csr_data;
            REG_STEP_LEN:  step_in = csr_data[11:0];
            REG_BOX_SIZE:  box_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in = command;
               if (command) begin
                  heading_in = random_angle;
                  tumbled_in = 1'b0;
                  disp_x_in  = '0;
                  disp_y_in  = '0;
                  state_in   = ST_WRAP;
               end else begin
                  tumbled_in = (random_draw < thr_ff);
                  if (random_draw < thr_ff) begin
                     heading_in = random_angle;
                  end
                  state_in = ST_MULK;
               end
            end
         end
         ST_MULK: begin
            if (z_head > QUARTER_TURN) begin
               z_in    = z_head - HALF_TURN;
               flip_in = 1'b1;
            end else if (z_head < -QUARTER_TURN) begin
               z_in    = z_head + HALF_TURN;
               flip_in = 1'b1;
            end else begin
               z_in    = z_head;
               flip_in = 1'b0;
            end
            state_in = ST_LOADX;
         end
         ST_LOADX: begin
            x_in     = $signed(32'((prod_ff[41:0] + 42'd8192) >> 14));
            y_in     = '0;
            cnt_in   = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (!z_ff[33]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            disp_x_in = dsat_x;
            disp_y_in = dsat_y;
            state_in  = ST_WRAP;
         end
         ST_WRAP: begin
            if (wrap_x.done) begin
               pos_x_in = wrap_x.value;
               pos_y_in = wrap_y.value;
               if (cmd_ff) begin
                  sq_in    = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = prod_ff[2*DW-1:0];
            state_in = ST_SQADD;
         end
         ST_SQADD: begin
            sq_in    = (sq_ext[64:48] != '0) ? 48'hFFFF_FFFF_FFFF : sq_ext[47:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // output register frees up in the cycle of its transfer
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sq_ff, heading_ff, pos_y_ff, pos_x_ff};
               rsp_user_in  = tumbled_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         step_ff      <= STEP_LEN_RESET;
         box_ff       <= BOX_SIZE_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         heading_ff   <= '0;
         disp_x_ff    <= '0;
         disp_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         step_ff      <= step_in;
         box_ff       <= box_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         heading_ff   <= heading_in;
         disp_x_ff    <= disp_x_in;
         disp_y_ff    <= disp_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      tumbled_ff  <= tumbled_in;
      flip_ff     <= flip_in;
      cnt_ff      <= cnt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("ready again right after an input transfer");

   a_wrap_in_state: assert property (@(posedge clock) disable iff (reset)
      wrap_x.done |-> (state_ff == ST_WRAP))
      else $error("remainder finished outside the wrap state");

   a_wrap_lockstep: assert property (@(posedge clock) disable iff (reset)
      wrap_x.done == wrap_y.done)
      else $error("axis remainders out of step");

endmodule
